// ----- sv/cdns_pkg.sv -----
// Shared types, constants and tables for the character display nibble sequencer.
package cdns_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PWRUP,
    ST_RAW,
    ST_BYTE,
    ST_POLL,
    ST_SAMP,
    ST_RESTORE
  } state_t;

  typedef enum logic [1:0] {
    REQ_INIT,
    REQ_CMD,
    REQ_DATA,
    REQ_SAMPLE
  } req_t;

  typedef enum logic [1:0] {
    NIB_ZERO,
    NIB_RAW,
    NIB_HI,
    NIB_LO
  } nib_sel_t;

  typedef enum logic [2:0] {
    HOLD_0,
    HOLD_10,
    HOLD_50,
    HOLD_5000,
    HOLD_50000,
    HOLD_RESTORE
  } hold_sel_t;

  localparam logic [15:0] HOLD_US_10    = 16'd10;
  localparam logic [15:0] HOLD_US_50    = 16'd50;
  localparam logic [15:0] HOLD_US_5000  = 16'd5000;
  localparam logic [15:0] HOLD_US_50000 = 16'd50000;

  localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;

  localparam logic [3:0] RAW_WAKE     = 4'h3;
  localparam logic [3:0] RAW_EXT      = 4'h8;
  localparam logic [3:0] RAW_BUS4     = 4'h2;
  localparam logic [3:0] RAW_FUNC_LO  = 4'h8;

  localparam logic [2:0] RAW_FIRST    = 3'd0;
  localparam logic [2:0] RAW_EXT_IDX  = 3'd1;
  localparam logic [2:0] RAW_LAST     = 3'd4;
  localparam logic [2:0] SCRIPT_LAST  = 3'd4;

  localparam logic [1:0] SUB_SET  = 2'd0;
  localparam logic [1:0] SUB_HIGH = 2'd1;
  localparam logic [1:0] SUB_LOW  = 2'd2;

  typedef struct packed {
    logic      emit;
    logic      rs_byte;
    logic      rw;
    logic      e;
    nib_sel_t  nib_sel;
    logic [3:0] raw_nib;
    logic      drive;
    hold_sel_t hold_sel;
    logic      want;
    logic      last;
    logic      start_init;
    logic      start_byte;
    logic      take_sample;
    logic      set_poll;
    logic      next_script;
    logic      finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic polling;
    logic in_init;
    logic script_more;
    logic newer;
    logic busy;
  } dp_stat_t;

  function automatic logic [7:0] script_cmd(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = CMD_DISPLAY_OFF;
      3'd1:    v = CMD_CLEAR;
      3'd2:    v = CMD_ENTRY_MODE;
      3'd3:    v = CMD_HOME;
      3'd4:    v = CMD_DISPLAY_ON;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] raw_nibble(input logic [2:0] idx);
    logic [3:0] v;
    unique case (idx)
      3'd0:    v = RAW_WAKE;
      3'd1:    v = RAW_EXT;
      3'd2:    v = RAW_BUS4;
      3'd3:    v = RAW_BUS4;
      3'd4:    v = RAW_FUNC_LO;
      default: v = 4'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/cdns_ctrl.sv -----
// Step sequencer state machine: walks init, byte, poll and sample runs one pin step a beat while the output has room.
module cdns_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_req,
  output logic                in_ready,
  input  cdns_pkg::dp_stat_t  stat,
  output cdns_pkg::ctrl_cmd_t cmd
);
  import cdns_pkg::*;

  state_t     state, state_next;
  logic [1:0] sub, sub_next;
  logic [2:0] raw_idx, raw_idx_next;
  logic       lo, lo_next;
  logic       accept;
  logic       go;
  logic       more_script;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign go          = stat.out_free;
  assign more_script = stat.in_init && stat.script_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sub     <= SUB_SET;
      raw_idx <= RAW_FIRST;
      lo      <= 1'b0;
    end else begin
      state   <= state_next;
      sub     <= sub_next;
      raw_idx <= raw_idx_next;
      lo      <= lo_next;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    sub_next     = sub;
    raw_idx_next = raw_idx;
    lo_next      = lo;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          sub_next = SUB_SET;
          lo_next  = 1'b0;
          if (in_req == REQ_SAMPLE) begin
            if (stat.polling) state_next = ST_SAMP;
          end else if (!stat.polling) begin
            state_next = (in_req == REQ_INIT) ? ST_PWRUP : ST_BYTE;
          end
        end
      end
      ST_PWRUP: begin
        if (go) begin
          state_next   = ST_RAW;
          raw_idx_next = RAW_FIRST;
          sub_next     = SUB_SET;
        end
      end
      ST_RAW: begin
        if (go) begin
          if (sub == SUB_LOW) begin
            sub_next = SUB_SET;
            if (raw_idx == RAW_LAST) begin
              state_next = ST_BYTE;
              lo_next    = 1'b0;
            end else if (raw_idx == RAW_FIRST && !stat.newer) begin
              raw_idx_next = RAW_EXT_IDX + 3'd1;
            end else begin
              raw_idx_next = raw_idx + 3'd1;
            end
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      ST_BYTE: begin
        if (go) begin
          if (sub == SUB_LOW) begin
            sub_next = SUB_SET;
            if (lo) state_next = ST_POLL;
            else    lo_next    = 1'b1;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      ST_POLL: begin
        if (go) begin
          if (sub == SUB_HIGH) begin
            sub_next   = SUB_SET;
            state_next = ST_IDLE;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      ST_SAMP: begin
        if (go) begin
          if (sub == SUB_LOW) begin
            sub_next   = SUB_SET;
            state_next = stat.busy ? ST_POLL : ST_RESTORE;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
      end
      ST_RESTORE: begin
        if (go) begin
          sub_next = SUB_SET;
          lo_next  = 1'b0;
          state_next = more_script ? ST_BYTE : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.nib_sel  = NIB_ZERO;
    cmd.hold_sel = HOLD_0;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_req != REQ_SAMPLE && !stat.polling) begin
          cmd.start_init = (in_req == REQ_INIT);
          cmd.start_byte = (in_req != REQ_INIT);
        end
        cmd.take_sample = accept && (in_req == REQ_SAMPLE) && stat.polling;
      end
      ST_PWRUP: begin
        cmd.emit     = go;
        cmd.drive    = 1'b1;
        cmd.hold_sel = HOLD_50000;
      end
      ST_RAW: begin
        cmd.emit     = go;
        cmd.nib_sel  = NIB_RAW;
        cmd.raw_nib  = raw_nibble(raw_idx);
        cmd.drive    = 1'b1;
        cmd.e        = (sub == SUB_HIGH);
        cmd.hold_sel = (sub == SUB_LOW) ? HOLD_5000 : HOLD_50;
      end
      ST_BYTE: begin
        cmd.emit     = go;
        cmd.rs_byte  = 1'b1;
        cmd.nib_sel  = lo ? NIB_LO : NIB_HI;
        cmd.drive    = 1'b1;
        cmd.e        = (sub == SUB_HIGH);
        cmd.hold_sel = (sub == SUB_LOW) ? HOLD_0 : HOLD_50;
      end
      ST_POLL: begin
        cmd.emit     = go;
        cmd.rw       = 1'b1;
        cmd.e        = (sub == SUB_HIGH);
        cmd.hold_sel = (sub == SUB_HIGH) ? HOLD_10 : HOLD_0;
        cmd.want     = (sub == SUB_HIGH);
        cmd.last     = (sub == SUB_HIGH);
        cmd.set_poll = go && (sub == SUB_HIGH);
      end
      ST_SAMP: begin
        cmd.emit     = go;
        cmd.rw       = 1'b1;
        cmd.e        = (sub == SUB_HIGH);
        cmd.hold_sel = (sub == SUB_HIGH) ? HOLD_50 : HOLD_0;
      end
      ST_RESTORE: begin
        cmd.emit        = go;
        cmd.drive       = 1'b1;
        cmd.hold_sel    = HOLD_RESTORE;
        cmd.last        = !more_script;
        cmd.next_script = go && more_script;
        cmd.finish      = go && !more_script;
      end
      default: cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("step issued while output register full");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("sequencer busy after final step");

  a_stray_sample: assert property (@(posedge clk) disable iff (rst)
    (accept && in_req == REQ_SAMPLE && !stat.polling) |=> (state == ST_IDLE))
    else $error("busy sample while idle was not ignored");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    sub != 2'd3)
    else $error("step counter out of range");
`endif

endmodule

// ----- sv/cdns_dp.sv -----
// Datapath: config register, sequence state, latched byte and the registered output step.
module cdns_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  logic [1:0]          in_req,
  input  logic [7:0]          in_byte,
  input  logic                in_busy,
  input  cdns_pkg::ctrl_cmd_t cmd,
  output cdns_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_rs,
  output logic                out_rw,
  output logic                out_e,
  output logic [3:0]          out_nib,
  output logic                out_drive,
  output logic [15:0]         out_hold,
  output logic                out_want,
  output logic                out_last
);
  import cdns_pkg::*;

  logic       newer;
  logic       polling;
  logic       in_init;
  logic [2:0] script_index;
  logic [7:0] byte_reg;
  logic       rs_reg;
  logic       busy_reg;
  logic [3:0] nib;
  logic [15:0] hold;

  // single register at word 0; paddr[2] picks the word
  always_ff @(posedge clk) begin
    if (rst) begin
      newer <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      newer <= pwdata[0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {31'd0, newer};

  always_ff @(posedge clk) begin
    if (rst) begin
      polling      <= 1'b0;
      in_init      <= 1'b0;
      script_index <= 3'd0;
    end else begin
      if (cmd.start_init) begin
        in_init      <= 1'b1;
        script_index <= 3'd0;
      end
      if (cmd.start_byte) begin
        in_init      <= 1'b0;
        script_index <= 3'd0;
      end
      if (cmd.set_poll) polling <= 1'b1;
      if (cmd.next_script) script_index <= script_index + 3'd1;
      if (cmd.finish) begin
        in_init      <= 1'b0;
        script_index <= 3'd0;
        polling      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_init) begin
      byte_reg <= script_cmd(3'd0);
      rs_reg   <= 1'b0;
    end
    if (cmd.start_byte) begin
      byte_reg <= in_byte;
      rs_reg   <= (in_req == REQ_DATA);
    end
    if (cmd.next_script) begin
      byte_reg <= script_cmd(script_index + 3'd1);
      rs_reg   <= 1'b0;
    end
    if (cmd.take_sample) busy_reg <= in_busy;
  end

  assign stat.out_free    = !out_valid || out_ready;
  assign stat.polling     = polling;
  assign stat.in_init     = in_init;
  assign stat.script_more = (script_index < SCRIPT_LAST);
  assign stat.newer       = newer;
  assign stat.busy        = busy_reg;

  always_comb begin
    unique case (cmd.nib_sel)
      NIB_ZERO: nib = 4'h0;
      NIB_RAW:  nib = cmd.raw_nib;
      NIB_HI:   nib = byte_reg[7:4];
      NIB_LO:   nib = byte_reg[3:0];
      default:  nib = 4'h0;
    endcase
  end

  always_comb begin
    unique case (cmd.hold_sel)
      HOLD_0:       hold = 16'd0;
      HOLD_10:      hold = HOLD_US_10;
      HOLD_50:      hold = HOLD_US_50;
      HOLD_5000:    hold = HOLD_US_5000;
      HOLD_50000:   hold = HOLD_US_50000;
      HOLD_RESTORE: hold = in_init ? HOLD_US_5000 : 16'd0;
      default:      hold = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rs    <= cmd.rs_byte && rs_reg;
      out_rw    <= cmd.rw;
      out_e     <= cmd.e;
      out_nib   <= nib;
      out_drive <= cmd.drive;
      out_hold  <= hold;
      out_want  <= cmd.want;
      out_last  <= cmd.last;
    end
  end

`ifndef SYNTHESIS
  a_script_range: assert property (@(posedge clk) disable iff (rst)
    script_index <= SCRIPT_LAST)
    else $error("script index past end of init script");

  a_script_only_in_init: assert property (@(posedge clk) disable iff (rst)
    cmd.next_script |-> (in_init && polling))
    else $error("script advance outside init polling");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("output step overwritten while stalled");
`endif

endmodule

// ----- sv/char_display_nibble_sequencer.sv -----
// Top level of the character display nibble sequencer.
// Turns init, command, data and busy-sample beats into runs of 4-bit bus pin steps, one step
// per cycle into a registered output while the output side keeps taking them. An init run is
// 24 steps (21 with newer_panel clear), a command or data byte 8 steps, a busy sample 5 steps
// when still busy, 4 when clear at the end, and 12 when clear mid init script. A new input
// beat is taken only once the step sequencer in the controller has issued the final step of
// the previous run, so no new beat is accepted while a run is in progress; ignored beats
// produce nothing. The newer_panel register sits at address 0 of the APB port.
module char_display_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value[7:0], busy_level[8], zero fill
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // rw_level[0], enable_level[1], nibble_out[5:2],
                                 // drive_data[6], hold_us[22:7], want_sample[23]
  output logic [0:0]  m_tuser,   // rs_level[0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cdns_pkg::*;

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic        out_rs;
  logic        out_rw;
  logic        out_e;
  logic [3:0]  out_nib;
  logic        out_drive;
  logic [15:0] out_hold;
  logic        out_want;

  assign pready = 1'b1;

  cdns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdns_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_req    (s_tuser),
    .in_byte   (s_tdata[7:0]),
    .in_busy   (s_tdata[8]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rs    (out_rs),
    .out_rw    (out_rw),
    .out_e     (out_e),
    .out_nib   (out_nib),
    .out_drive (out_drive),
    .out_hold  (out_hold),
    .out_want  (out_want),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_want, out_hold, out_drive, out_nib, out_e, out_rw};
  assign m_tuser = out_rs;

endmodule
